// File: design/counting_event_trigger_table_macros.svh
// assertion macros used by the trigger table design file
`ifndef COUNTING_EVENT_TRIGGER_TABLE_MACROS_SVH
`define COUNTING_EVENT_TRIGGER_TABLE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CETT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define CETT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: design/cett_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cett_pkg
// Types and constants of the counting event trigger table.
// ----------------------------------------------------------------------------
package cett_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 16;
    localparam int TAG_WIDTH   = 8;

    // port field widths
    localparam int CNT_DW     = 64;
    localparam int TAG_PORT_W = 8;

    // derived widths
    localparam int CNT_W      = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int TAG_KEEP_W = (TAG_WIDTH < TAG_PORT_W) ? TAG_WIDTH : TAG_PORT_W;

    // input operation codes
    typedef enum logic [1:0] {
        OP_EVENT = 2'd0,
        OP_SET   = 2'd1,
        OP_ADD   = 2'd2,
        OP_POST  = 2'd3
    } t_op;

    // result kind and status codes
    localparam logic KIND_FIRED  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // input word
    typedef struct packed {
        logic [1:0]            op;
        logic                  fail;
        logic [CNT_DW-1:0]     length;
        logic                  count_bytes;
        logic [CNT_DW-1:0]     success_value;
        logic [CNT_DW-1:0]     failure_value;
        logic [CNT_DW-1:0]     threshold;
        logic [TAG_PORT_W-1:0] tag;
    } t_in_word;

    // result word
    typedef struct packed {
        logic                  kind;
        logic [TAG_PORT_W-1:0] fired_tag;
        logic                  status;
        logic [CNT_DW-1:0]     success_total;
        logic [CNT_DW-1:0]     failure_total;
        logic                  last;
    } t_out_word;

endpackage

// File: design/cett_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cett_in_if
// Valid/ready channel carrying input words of the trigger table.
// ----------------------------------------------------------------------------
interface cett_in_if;
    import cett_pkg::*;

    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/cett_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cett_out_if
// Valid/ready channel carrying result words of the trigger table.
// ----------------------------------------------------------------------------
interface cett_out_if;
    import cett_pkg::*;

    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/counting_event_trigger_table.sv
// Sequence: a word is taken in idle; the success then the failure counter update, then
// the total is formed, the table is scanned oldest first and the status word is sent.
// A post skips the counter updates and checks its own threshold instead of a scan.
// No new word is taken until the status word of the last one has been sent.
// Reset: synchronous active low; counters and entry count clear, table contents stay.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counting_event_trigger_table
// Success/failure counters with a table of pending triggered operations,
// scanned oldest first after each counter change by one shared adder and
// comparator under a small sequencer.
// ----------------------------------------------------------------------------
`include "counting_event_trigger_table_macros.svh"

module counting_event_trigger_table (
    input  logic i_clk,
    input  logic i_rst_n,
    cett_in_if.sink    i_in,
    cett_out_if.source o_out
);
    import cett_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPD_S,
        ST_UPD_F,
        ST_TOTAL,
        ST_POST,
        ST_SCAN,
        ST_STATUS
    } t_state;

    // control and payload registers
    t_state            r_state, n_state;
    t_in_word          r_in, n_in;
    logic [CNT_DW-1:0] r_succ, n_succ;
    logic [CNT_DW-1:0] r_fail, n_fail;
    logic [CNT_DW-1:0] r_total, n_total;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_rd, n_rd;
    logic [CNT_W-1:0]  r_wr, n_wr;
    logic              r_status, n_status;
    logic              r_out_valid, n_out_valid;
    t_out_word         r_out_data, n_out_data;

    // pending table, no reset: only entries below the count are read
    logic [CNT_DW-1:0]     r_thr [TABLE_DEPTH];
    logic [TAG_KEEP_W-1:0] r_tag [TABLE_DEPTH];

    // table write port
    logic                  tbl_we;
    logic [IDX_W-1:0]      tbl_addr;
    logic [CNT_DW-1:0]     tbl_thr;
    logic [TAG_KEEP_W-1:0] tbl_tag;

    // shared adder and comparator
    logic [CNT_DW-1:0] add_a, add_b, add_sum;
    logic [CNT_DW-1:0] cmp_b;
    logic              hit;
    logic              can_emit;
    logic [IDX_W-1:0]  rd_idx;

    assign rd_idx   = r_rd[IDX_W-1:0];
    assign add_sum  = add_a + add_b;
    assign hit      = (r_total >= cmp_b);
    assign can_emit = !r_out_valid || o_out.ready;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_in        = r_in;
        n_succ      = r_succ;
        n_fail      = r_fail;
        n_total     = r_total;
        n_count     = r_count;
        n_rd        = r_rd;
        n_wr        = r_wr;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        tbl_we      = 1'b0;
        tbl_addr    = r_wr[IDX_W-1:0];
        tbl_thr     = r_thr[rd_idx];
        tbl_tag     = r_tag[rd_idx];
        add_a       = r_succ;
        add_b       = r_fail;
        cmp_b       = (r_state == ST_POST) ? r_in.threshold : r_thr[rd_idx];

        // output word taken
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_in     = i_in.data;
                    n_status = STATUS_OK;
                    n_state  = (i_in.data.op == OP_POST) ? ST_TOTAL : ST_UPD_S;
                end
            end
            // success counter update
            ST_UPD_S: begin
                add_a = (r_in.op == OP_SET) ? r_in.success_value : r_succ;
                case (r_in.op)
                    OP_EVENT: begin
                        if (r_in.fail) begin
                            add_b = '0;
                        end else if (r_in.count_bytes) begin
                            add_b = r_in.length;
                        end else begin
                            add_b = CNT_DW'(1);
                        end
                    end
                    OP_ADD:  add_b = r_in.success_value;
                    default: add_b = '0;
                endcase
                n_succ  = add_sum;
                n_state = ST_UPD_F;
            end
            // failure counter update
            ST_UPD_F: begin
                add_a = (r_in.op == OP_SET) ? r_in.failure_value : r_fail;
                case (r_in.op)
                    OP_EVENT: add_b = r_in.fail ? CNT_DW'(1) : '0;
                    OP_ADD:   add_b = r_in.failure_value;
                    default:  add_b = '0;
                endcase
                n_fail  = add_sum;
                n_state = ST_TOTAL;
            end
            // total of both counters
            ST_TOTAL: begin
                n_total = add_sum;
                n_rd    = '0;
                n_wr    = '0;
                n_state = (r_in.op == OP_POST) ? ST_POST : ST_SCAN;
            end
            // post: fire at once, reject when full, else append
            ST_POST: begin
                if (hit) begin
                    if (can_emit) begin
                        n_out_valid              = 1'b1;
                        n_out_data.kind          = KIND_FIRED;
                        n_out_data.fired_tag     =
                            TAG_PORT_W'(r_in.tag[TAG_KEEP_W-1:0]);
                        n_out_data.status        = STATUS_OK;
                        n_out_data.success_total = r_succ;
                        n_out_data.failure_total = r_fail;
                        n_out_data.last          = 1'b0;
                        n_state                  = ST_STATUS;
                    end
                end else if (r_count == CNT_W'(TABLE_DEPTH)) begin
                    n_status = STATUS_FULL;
                    n_state  = ST_STATUS;
                end else begin
                    tbl_we   = 1'b1;
                    tbl_addr = r_count[IDX_W-1:0];
                    tbl_thr  = r_in.threshold;
                    tbl_tag  = r_in.tag[TAG_KEEP_W-1:0];
                    n_count  = r_count + CNT_W'(1);
                    n_state  = ST_STATUS;
                end
            end
            // one entry per cycle while the output can take a fired word, oldest first, compacting survivors
            ST_SCAN: begin
                if (r_rd == r_count) begin
                    n_count = r_wr;
                    n_state = ST_STATUS;
                end else if (hit) begin
                    if (can_emit) begin
                        n_out_valid              = 1'b1;
                        n_out_data.kind          = KIND_FIRED;
                        n_out_data.fired_tag     = TAG_PORT_W'(r_tag[rd_idx]);
                        n_out_data.status        = STATUS_OK;
                        n_out_data.success_total = r_succ;
                        n_out_data.failure_total = r_fail;
                        n_out_data.last          = 1'b0;
                        n_rd                     = r_rd + CNT_W'(1);
                    end
                end else begin
                    tbl_we = 1'b1;
                    n_wr   = r_wr + CNT_W'(1);
                    n_rd   = r_rd + CNT_W'(1);
                end
            end
            // closing status word
            ST_STATUS: begin
                if (can_emit) begin
                    n_out_valid              = 1'b1;
                    n_out_data.kind          = KIND_STATUS;
                    n_out_data.fired_tag     = '0;
                    n_out_data.status        = r_status;
                    n_out_data.success_total = r_succ;
                    n_out_data.failure_total = r_fail;
                    n_out_data.last          = 1'b1;
                    n_state                  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_succ      <= '0;
            r_fail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_succ      <= n_succ;
            r_fail      <= n_fail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_in       <= n_in;
        r_total    <= n_total;
        r_rd       <= n_rd;
        r_wr       <= n_wr;
        r_status   <= n_status;
        r_out_data <= n_out_data;
    end

    // table write
    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_thr[tbl_addr] <= tbl_thr;
            r_tag[tbl_addr] <= tbl_tag;
        end
    end

    // checks
    `CETT_ASSERT_NOW(a_count_max, i_clk, i_rst_n, 1'b1,
        r_count <= CNT_W'(TABLE_DEPTH), "entry count above table depth")
    `CETT_ASSERT_NOW(a_scan_order, i_clk, i_rst_n, r_state == ST_SCAN,
        (r_wr <= r_rd) && (r_rd <= r_count), "scan pointers out of order")
    `CETT_ASSERT_NEXT(a_count_hold, i_clk, i_rst_n,
        (r_state != ST_SCAN) && (r_state != ST_POST), $stable(r_count),
        "entry count changed outside scan or post")

endmodule

// File: sim/cett_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cett_result_checker
// Watches both channels of the trigger table, keeps its own copy of the
// counters and of the pending table, predicts the result words of every
// accepted input word and compares them in order with what comes out.
// ----------------------------------------------------------------------------
module cett_result_checker
    import cett_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_word  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_word i_out_data,
    output int        o_fail_count,
    output int        o_pending
);

    // shadow counters and pending table, oldest entry at index 0
    logic [CNT_DW-1:0]     success_q;
    logic [CNT_DW-1:0]     failure_q;
    logic [CNT_DW-1:0]     pend_thr [TABLE_DEPTH];
    logic [TAG_PORT_W-1:0] pend_tag [TABLE_DEPTH];
    int                    pend_n;

    // result words still owed by the block, oldest first
    t_out_word expected_results[$];

    // queue one result word carrying the current counters
    task automatic queue_result(input logic kind, input logic [TAG_PORT_W-1:0] tag,
                                input logic st, input logic is_last);
        t_out_word r;
        r.kind          = kind;
        r.fired_tag     = tag;
        r.status        = st;
        r.success_total = success_q;
        r.failure_total = failure_q;
        r.last          = is_last;
        expected_results.push_back(r);
    endtask

    // fire every entry whose threshold is met, compact the rest in order
    task automatic fire_met_entries();
        logic [CNT_DW-1:0] total;
        int                kept;
        total = success_q + failure_q;
        kept  = 0;
        for (int rd = 0; rd < pend_n; rd++) begin
            if (total >= pend_thr[rd]) begin
                queue_result(KIND_FIRED, pend_tag[rd], STATUS_OK, 1'b0);
            end else begin
                pend_thr[kept] = pend_thr[rd];
                pend_tag[kept] = pend_tag[rd];
                kept++;
            end
        end
        pend_n = kept;
    endtask

    // work out the result words of one accepted input word
    task automatic predict_word(input t_in_word w);
        logic                  post_status;
        logic [TAG_PORT_W-1:0] kept_tag;
        post_status = STATUS_OK;
        case (t_op'(w.op))
            OP_EVENT: begin
                if (w.fail)
                    failure_q = failure_q + 1'b1;
                else if (w.count_bytes)
                    success_q = success_q + w.length;
                else
                    success_q = success_q + 1'b1;
                fire_met_entries();
            end
            OP_SET: begin
                success_q = w.success_value;
                failure_q = w.failure_value;
                fire_met_entries();
            end
            OP_ADD: begin
                success_q = success_q + w.success_value;
                failure_q = failure_q + w.failure_value;
                fire_met_entries();
            end
            OP_POST: begin
                // only the low tag bits survive
                kept_tag = '0;
                kept_tag[TAG_KEEP_W-1:0] = w.tag[TAG_KEEP_W-1:0];
                if (success_q + failure_q >= w.threshold) begin
                    queue_result(KIND_FIRED, kept_tag, STATUS_OK, 1'b0);
                end else if (pend_n >= TABLE_DEPTH) begin
                    post_status = STATUS_FULL;
                end else begin
                    pend_thr[pend_n] = w.threshold;
                    pend_tag[pend_n] = kept_tag;
                    pend_n++;
                end
            end
            default: begin
            end
        endcase
        queue_result(KIND_STATUS, '0, post_status, 1'b1);
    endtask

    // compare one result word with the oldest expectation
    task automatic check_result(input t_out_word got);
        t_out_word want;
        logic      bad;
        if (expected_results.size() == 0) begin
            if (o_fail_count < 10)
                $display("%0t: unexpected result word: kind %0d tag %h status %0d last %0d",
                         $realtime, got.kind, got.fired_tag, got.status, got.last);
            o_fail_count++;
        end else begin
            want = expected_results.pop_front();
            bad  = (got.kind !== want.kind) || (got.fired_tag !== want.fired_tag) ||
                   (got.status !== want.status) ||
                   (got.success_total !== want.success_total) ||
                   (got.failure_total !== want.failure_total) ||
                   (got.last !== want.last);
            if (bad) begin
                if (o_fail_count < 10) begin
                    $display("%0t: result mismatch", $realtime);
                    $display("  expected kind %0d tag %h status %0d succ %h fail %h last %0d",
                             want.kind, want.fired_tag, want.status, want.success_total,
                             want.failure_total, want.last);
                    $display("  actual   kind %0d tag %h status %0d succ %h fail %h last %0d",
                             got.kind, got.fired_tag, got.status, got.success_total,
                             got.failure_total, got.last);
                end
                o_fail_count++;
            end
        end
    endtask

    // watch both channels
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            success_q    = '0;
            failure_q    = '0;
            pend_n       = 0;
            o_fail_count = 0;
            expected_results.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                predict_word(i_in_data);
            if (i_out_valid && i_out_ready)
                check_result(i_out_data);
        end
        o_pending = expected_results.size();
    end

endmodule

// File: sim/counting_event_trigger_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counting_event_trigger_table_tb
// Drives the trigger table with a directed opening (counter wraps, immediate
// and deferred firing, a full table, a scan that fires every entry) and then
// random words under several idle and stall mixes; a checker beside the
// block predicts and compares every result word.
// ----------------------------------------------------------------------------
module counting_event_trigger_table_tb;
    import cett_pkg::*;

    localparam int QUIET_LIMIT      = 2000;
    localparam int DRAIN_CYCLES     = 40;
    localparam int RANDOM_PER_PHASE = 31;

    localparam logic [CNT_DW-1:0] ALL_ONES = '1;

    logic i_clk;
    logic i_rst_n;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   fail_count;
    int   pending_count;
    int   quiet_cycles   = 0;

    cett_in_if  in_ch ();
    cett_out_if out_ch ();

    counting_event_trigger_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    cett_result_checker result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_ch.valid),
        .i_in_ready   (in_ch.ready),
        .i_in_data    (in_ch.data),
        .i_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .i_out_data   (out_ch.data),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side back-pressure
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [CNT_DW-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // every field random, so fields that do not apply carry noise
    function automatic t_in_word noise_word();
        t_in_word w;
        w.op            = 2'($urandom);
        w.fail          = 1'($urandom);
        w.length        = rand64();
        w.count_bytes   = 1'($urandom);
        w.success_value = rand64();
        w.failure_value = rand64();
        w.threshold     = rand64();
        w.tag           = TAG_PORT_W'($urandom);
        return w;
    endfunction

    function automatic t_in_word event_word(input logic failed, input logic bytes,
                                            input logic [CNT_DW-1:0] len);
        t_in_word w;
        w             = noise_word();
        w.op          = OP_EVENT;
        w.fail        = failed;
        w.count_bytes = bytes;
        w.length      = len;
        return w;
    endfunction

    function automatic t_in_word counters_word(input t_op op, input logic [CNT_DW-1:0] succ,
                                               input logic [CNT_DW-1:0] fails);
        t_in_word w;
        w               = noise_word();
        w.op            = op;
        w.success_value = succ;
        w.failure_value = fails;
        return w;
    endfunction

    function automatic t_in_word post_word(input logic [CNT_DW-1:0] thr,
                                           input logic [TAG_PORT_W-1:0] tag);
        t_in_word w;
        w           = noise_word();
        w.op        = OP_POST;
        w.threshold = thr;
        w.tag       = tag;
        return w;
    endfunction

    // mostly small counts and thresholds so posts wait and events fire them
    function automatic t_in_word random_word();
        t_in_word w;
        int       pick;
        int       size_pick;
        pick      = $urandom_range(0, 99);
        size_pick = $urandom_range(0, 9);
        if (pick < 35) begin
            if (size_pick < 7)
                w = post_word(CNT_DW'($urandom_range(0, 80)), TAG_PORT_W'($urandom));
            else if (size_pick < 9)
                w = post_word({1'b1, 63'(rand64())}, TAG_PORT_W'($urandom));
            else
                w = post_word(rand64(), TAG_PORT_W'($urandom));
        end else if (pick < 65) begin
            w = event_word($urandom_range(0, 3) == 0, 1'($urandom),
                           (size_pick < 8) ? CNT_DW'($urandom_range(0, 8)) : rand64());
        end else if (pick < 80) begin
            if (size_pick < 8)
                w = counters_word(OP_ADD, CNT_DW'($urandom_range(0, 4)),
                                  CNT_DW'($urandom_range(0, 4)));
            else
                w = counters_word(OP_ADD, rand64(), rand64());
        end else begin
            if (size_pick < 8)
                w = counters_word(OP_SET, CNT_DW'($urandom_range(0, 30)),
                                  CNT_DW'($urandom_range(0, 30)));
            else if (size_pick < 9)
                w = counters_word(OP_SET, ALL_ONES - CNT_DW'($urandom_range(0, 20)),
                                  CNT_DW'($urandom_range(0, 20)));
            else
                w = counters_word(OP_SET, rand64(), rand64());
        end
        return w;
    endfunction

    // offer one word, idling first at random, and hold it until taken
    task automatic send_word(input t_in_word w);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // stimulus and verdict
    initial begin
        i_rst_n     <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // counting events of each flavor
        send_word(event_word(1'b0, 1'b0, rand64()));
        send_word(event_word(1'b0, 1'b1, 64'd5));
        send_word(event_word(1'b1, 1'b1, rand64()));
        // threshold already met, then two deferred posts fired in order
        send_word(post_word('0, 8'hFF));
        send_word(post_word(64'd10, 8'hAA));
        send_word(post_word(64'd9, 8'h55));
        send_word(event_word(1'b0, 1'b1, 64'd3));
        // total wraps to zero, then both counters wrap
        send_word(counters_word(OP_SET, ALL_ONES, 64'd1));
        send_word(counters_word(OP_ADD, 64'd1, ALL_ONES));
        // fill the table, post once more to a full table
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_word(post_word(ALL_ONES, TAG_PORT_W'(i * 17)));
        send_word(post_word(ALL_ONES - 1'b1, 8'h3C));
        // largest length reaches every threshold at once
        send_word(event_word(1'b0, 1'b1, ALL_ONES));

        // random words under each idle mix
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 45;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 45;
                end
                default: begin
                    send_idle_pct  = 21;
                    recv_stall_pct = 21;
                end
            endcase
            repeat (RANDOM_PER_PHASE) send_word(random_word());
        end
        in_ch.valid <= 1'b0;

        // drain, then give stray words a chance to show up
        do @(posedge i_clk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: counting_event_trigger_table.f
+incdir+design
design/cett_pkg.sv
design/cett_in_if.sv
design/cett_out_if.sv
design/counting_event_trigger_table.sv
sim/cett_result_checker.sv
sim/counting_event_trigger_table_tb.sv
